@@ sv/dwt_pkg.sv @@
// Shared types and codes for the data watchpoint table.
// No dependencies; dwt_ctrl, dwt_datapath and the top level import this package.
`timescale 1ns / 1ps

package dwt_pkg;

    localparam logic [1:0] OP_SET     = 2'd0;
    localparam logic [1:0] OP_OBSERVE = 2'd1;
    localparam logic [1:0] OP_REARM   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NO_ENTRY = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] watch_address;
        logic [31:0] data_value;
        logic        change_mode;
        logic [31:0] present_contents;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        fired;
        logic [3:0]  slot_index;
        logic [31:0] new_contents;
    } t_rsp;

    typedef struct packed {
        logic [31:0] address;
        logic [31:0] reference;
        logic        on_change;
        logic        asleep;
    } t_entry;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

@@ sv/dwt_if.sv @@
// Request and response channel interfaces of the data watchpoint table.
// Valid/ready handshake; a beat moves when both are high at a clock edge.
`timescale 1ns / 1ps

interface dwt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] watch_address;
    logic [31:0] data_value;
    logic        change_mode;
    logic [31:0] present_contents;

    modport source (
        output valid, opcode, watch_address, data_value, change_mode, present_contents,
        input  ready
    );
    modport sink (
        input  valid, opcode, watch_address, data_value, change_mode, present_contents,
        output ready
    );
endinterface

interface dwt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        fired;
    logic [3:0]  slot_index;
    logic [31:0] new_contents;

    modport source (
        output valid, status, fired, slot_index, new_contents,
        input  ready
    );
    modport sink (
        input  valid, status, fired, slot_index, new_contents,
        output ready
    );
endinterface

@@ sv/dwt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dwt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/dwt_ctrl.sv @@
// Sequencer of the data watchpoint table: accept, scan, drain, commit.
// Depends on dwt_pkg for the command and status structs.
`timescale 1ns / 1ps

module dwt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dwt_pkg::t_sts i_sts,
    output dwt_pkg::t_cmd o_cmd
);
    import dwt_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EXEC  = 2'd3;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.scan   = (r_state == S_SCAN);
    assign o_cmd.commit = (r_state == S_EXEC) && i_sts.out_free;

endmodule

@@ sv/dwt_datapath.sv @@
// Datapath of the data watchpoint table: entry RAM, valid bits, scan
// compare, update logic and result register. Depends on dwt_pkg and dwt_ram.
`timescale 1ns / 1ps

module dwt_datapath #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dwt_pkg::t_cmd i_cmd,
    output dwt_pkg::t_sts o_sts,
    input  dwt_pkg::t_req i_req,
    output dwt_pkg::t_rsp o_rsp,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready
);
    import dwt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ENT_W = $bits(t_entry);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    t_req                   r_req;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [IDX_W-1:0]       r_idx;
    logic [IDX_W-1:0]       r_rd_idx;
    logic                   r_rd_pend;
    logic                   r_hit;
    logic [IDX_W-1:0]       r_hit_idx;
    t_entry                 r_hit_entry;
    logic                   r_free;
    logic [IDX_W-1:0]       r_free_idx;
    t_rsp                   r_rsp;
    t_rsp                   n_rsp;
    logic                   r_rsp_valid;

    logic [ENT_W-1:0] rd_data;
    t_entry           rd_entry;
    logic             rd_match;
    logic             rd_empty;
    logic             wr_req;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    t_entry           wr_entry;
    logic             set_valid;
    logic             trigger;

    function automatic logic [3:0] slot4(input logic [IDX_W-1:0] s);
        logic [IDX_W+3:0] w;
        w = {4'b0000, s};
        return w[3:0];
    endfunction

    dwt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_idx),
        .i_wr_data (wr_entry),
        .i_rd_en   (i_cmd.scan),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    assign rd_entry = rd_data;
    assign rd_match = r_valid[r_rd_idx] && (rd_entry.address == r_req.watch_address);
    assign rd_empty = !r_valid[r_rd_idx];

    assign trigger = r_hit_entry.on_change ? (r_req.data_value != r_hit_entry.reference)
                                           : (r_req.data_value == r_hit_entry.reference);

    always_comb begin
        n_rsp     = '0;
        wr_req    = 1'b0;
        wr_idx    = r_hit_idx;
        wr_entry  = r_hit_entry;
        set_valid = 1'b0;
        case (r_req.opcode)
            OP_SET: begin
                if (r_hit || r_free) begin
                    wr_req = 1'b1;
                    if (!r_hit) begin
                        wr_idx    = r_free_idx;
                        set_valid = 1'b1;
                    end
                    wr_entry.address   = r_req.watch_address;
                    wr_entry.on_change = r_req.change_mode;
                    if (r_req.change_mode) begin
                        wr_entry.reference = r_req.present_contents;
                        wr_entry.asleep    = 1'b0;
                    end else begin
                        wr_entry.reference = r_req.data_value;
                        wr_entry.asleep    = (r_req.present_contents == r_req.data_value);
                    end
                    n_rsp.slot_index = slot4(wr_idx);
                end else begin
                    n_rsp.status = ST_FULL;
                end
            end
            OP_OBSERVE: begin
                if (!r_hit) begin
                    n_rsp.status = ST_NO_ENTRY;
                end else begin
                    n_rsp.slot_index = slot4(r_hit_idx);
                    if (!r_hit_entry.asleep && trigger) begin
                        wr_req             = 1'b1;
                        wr_entry.asleep    = 1'b1;
                        n_rsp.fired        = 1'b1;
                        n_rsp.new_contents = r_req.data_value;
                    end
                end
            end
            OP_REARM: begin
                if (!r_hit) begin
                    n_rsp.status = ST_NO_ENTRY;
                end else begin
                    n_rsp.slot_index = slot4(r_hit_idx);
                    wr_req           = 1'b1;
                    wr_entry.asleep  = 1'b0;
                    if (r_hit_entry.on_change) begin
                        wr_entry.reference = r_req.data_value;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign wr_en = i_cmd.commit && wr_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_idx       <= '0;
            r_rd_pend   <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.scan;
            if (i_cmd.load) begin
                r_idx  <= '0;
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else begin
                if (i_cmd.scan) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
                if (r_rd_pend && rd_match) begin
                    r_hit <= 1'b1;
                end
                if (r_rd_pend && rd_empty) begin
                    r_free <= 1'b1;
                end
            end
            if (i_cmd.commit && set_valid) begin
                r_valid[wr_idx] <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (r_rd_pend && rd_match && !r_hit) begin
            r_hit_idx   <= r_rd_idx;
            r_hit_entry <= rd_entry;
        end
        if (r_rd_pend && rd_empty && !r_free) begin
            r_free_idx <= r_rd_idx;
        end
        if (i_cmd.commit) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_sts.scan_last = (r_idx == LAST_IDX);
    assign o_sts.out_free  = !r_rsp_valid || i_rsp_ready;
    assign o_rsp           = r_rsp;
    assign o_rsp_valid     = r_rsp_valid;

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_rsp_valid || i_rsp_ready))
        else $error("result overwritten before it was taken");

    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit |-> r_valid[r_hit_idx])
        else $error("address match recorded on an invalid slot");

    a_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && set_valid) |=>
            (r_valid[$past(wr_idx)] &&
             ($countones(r_valid) == $countones($past(r_valid)) + 1)))
        else $error("new entry did not claim exactly one free slot");

endmodule

@@ sv/data_watchpoint_table_unit.sv @@
// Top level of the data watchpoint table.
// Depends on dwt_pkg, dwt_if, dwt_ram, dwt_ctrl and dwt_datapath.
`timescale 1ns / 1ps

// Every request beat gives exactly one response beat. A request passes
// these steps from acceptance to its response being loaded: accept it,
// read each table entry from the entry RAM and compare its address, one
// entry per cycle as the entry RAM has a single read port; compare the
// last entry read, then update the entry and load the result once the
// response register is free. Requests are taken one at a time; the
// response sits in an output register, so the next request is accepted
// while an earlier response still waits on the response channel.

module data_watchpoint_table_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input logic       i_clk,
    input logic       i_rst_n,
    dwt_req_if.sink   i_req,
    dwt_rsp_if.source o_rsp
);
    import dwt_pkg::*;

    t_cmd cmd;
    t_sts sts;
    t_req req;
    t_rsp rsp;
    logic in_ready;

    assign req.opcode           = i_req.opcode;
    assign req.watch_address    = i_req.watch_address;
    assign req.data_value       = i_req.data_value;
    assign req.change_mode      = i_req.change_mode;
    assign req.present_contents = i_req.present_contents;
    assign i_req.ready          = in_ready;

    dwt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dwt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (req),
        .o_rsp       (rsp),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready)
    );

    assign o_rsp.status       = rsp.status;
    assign o_rsp.fired        = rsp.fired;
    assign o_rsp.slot_index   = rsp.slot_index;
    assign o_rsp.new_contents = rsp.new_contents;

endmodule
